>>> rtl/core/slm_pkg.sv
`default_nettype none

package slm_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int JOB_MAX   = 3;
    localparam int JOB_CNT_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_ID_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_CHAR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_XOR       = 3'd4;

    localparam logic [BYTE_W-1:0]  RST_SERVICE_ID_FIRST = 8'd208;
    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT    = 5'd2;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_CHAR      = 8'd192;
    localparam logic [BYTE_W-1:0]  RST_FORCE_CHAR       = 8'd223;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_XOR       = 8'd32;

    localparam logic OP_LINK_RX  = 1'b0;
    localparam logic OP_TRANSMIT = 1'b1;

    localparam logic DEST_LINK    = 1'b0;
    localparam logic DEST_CHANNEL = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  service_id_first;
        logic [COUNT_W-1:0] channel_count;
        logic [BYTE_W-1:0]  escape_char;
        logic [BYTE_W-1:0]  force_char;
        logic [BYTE_W-1:0]  escape_xor;
    } t_cfg;

    // up to three bytes for one input item, emitted from byte 0 upward
    typedef struct packed {
        logic                             dest;
        logic [BYTE_W-1:0]                chan;
        logic [JOB_MAX-1:0][BYTE_W-1:0]   bytes;
        logic [JOB_CNT_W-1:0]             count;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/core/slm_front.sv
`default_nettype none

module slm_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire slm_pkg::t_cfg             i_cfg,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_opcode,
    input  wire logic [slm_pkg::BYTE_W-1:0] i_channel_id,
    input  wire logic [slm_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output slm_pkg::t_job                  o_job
);

    logic                       r_rx_ch_valid, n_rx_ch_valid;
    logic [slm_pkg::BYTE_W-1:0] r_rx_ch, n_rx_ch;
    logic                       r_rx_esc, n_rx_esc;
    logic                       r_tx_ch_valid, n_tx_ch_valid;
    logic [slm_pkg::BYTE_W-1:0] r_tx_ch, n_tx_ch;
    logic                       r_ls_valid, n_ls_valid;
    logic                       r_ls_esc, n_ls_esc;
    logic [slm_pkg::BYTE_W-1:0] r_ls_byte, n_ls_byte;

    logic                       accept;
    logic                       id_is_ch;
    logic                       data_is_ch;
    logic                       need_esc;
    logic                       need_id;
    logic [slm_pkg::BYTE_W-1:0] xored;
    logic [slm_pkg::BYTE_W:0]   id_end;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_job.count != '0);

    // channel range end computed one bit wider so it never wraps
    assign id_end     = {1'b0, i_cfg.service_id_first}
                      + {{(slm_pkg::BYTE_W + 1 - slm_pkg::COUNT_W){1'b0}}, i_cfg.channel_count};
    assign id_is_ch   = (i_channel_id >= i_cfg.service_id_first)
                      && ({1'b0, i_channel_id} < id_end);
    assign data_is_ch = (i_data_byte >= i_cfg.service_id_first)
                      && ({1'b0, i_data_byte} < id_end);
    assign need_esc   = (i_data_byte == i_cfg.escape_char) || (i_data_byte == i_cfg.force_char)
                      || data_is_ch;
    assign need_id    = !r_tx_ch_valid || (i_channel_id != r_tx_ch);
    assign xored      = i_data_byte ^ i_cfg.escape_xor;

    always_comb begin
        n_rx_ch_valid = r_rx_ch_valid;
        n_rx_ch       = r_rx_ch;
        n_rx_esc      = r_rx_esc;
        n_tx_ch_valid = r_tx_ch_valid;
        n_tx_ch       = r_tx_ch;
        n_ls_valid    = r_ls_valid;
        n_ls_esc      = r_ls_esc;
        n_ls_byte     = r_ls_byte;
        o_job.dest    = slm_pkg::DEST_LINK;
        o_job.chan    = '0;
        o_job.bytes   = '0;
        o_job.count   = '0;

        if (i_opcode == slm_pkg::OP_TRANSMIT) begin
            if (id_is_ch) begin
                if (need_id) begin
                    o_job.bytes[0] = i_channel_id;
                    if (need_esc) begin
                        o_job.bytes[1] = i_cfg.escape_char;
                        o_job.bytes[2] = xored;
                        o_job.count    = 2'd3;
                    end else begin
                        o_job.bytes[1] = i_data_byte;
                        o_job.count    = 2'd2;
                    end
                end else begin
                    if (need_esc) begin
                        o_job.bytes[0] = i_cfg.escape_char;
                        o_job.bytes[1] = xored;
                        o_job.count    = 2'd2;
                    end else begin
                        o_job.bytes[0] = i_data_byte;
                        o_job.count    = 2'd1;
                    end
                end
                n_ls_esc      = need_esc;
                n_ls_byte     = need_esc ? xored : i_data_byte;
                n_ls_valid    = 1'b1;
                n_tx_ch       = i_channel_id;
                n_tx_ch_valid = 1'b1;
            end
        end else begin
            // escape wins over channel ids, which win over force
            if (i_data_byte == i_cfg.escape_char) begin
                n_rx_esc = 1'b1;
            end else if (data_is_ch) begin
                n_rx_ch       = i_data_byte;
                n_rx_ch_valid = 1'b1;
            end else if ((i_data_byte == i_cfg.force_char) && r_ls_valid) begin
                o_job.bytes[0] = r_tx_ch;
                if (r_ls_esc) begin
                    o_job.bytes[1] = i_cfg.escape_char;
                    o_job.bytes[2] = r_ls_byte;
                    o_job.count    = 2'd3;
                end else begin
                    o_job.bytes[1] = r_ls_byte;
                    o_job.count    = 2'd2;
                end
                n_ls_valid = 1'b0;
            end else begin
                n_rx_esc    = 1'b0;
                o_job.count = 2'd1;
                if (r_rx_ch_valid) begin
                    o_job.dest     = slm_pkg::DEST_CHANNEL;
                    o_job.chan     = r_rx_ch;
                    o_job.bytes[0] = r_rx_esc ? xored : i_data_byte;
                end else begin
                    // no receive channel yet: ask the far end to resend
                    o_job.bytes[0] = i_cfg.force_char;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_ch_valid <= 1'b0;
            r_rx_ch       <= '0;
            r_rx_esc      <= 1'b0;
            r_tx_ch_valid <= 1'b0;
            r_tx_ch       <= '0;
            r_ls_valid    <= 1'b0;
            r_ls_esc      <= 1'b0;
            r_ls_byte     <= '0;
        end else if (accept) begin
            r_rx_ch_valid <= n_rx_ch_valid;
            r_rx_ch       <= n_rx_ch;
            r_rx_esc      <= n_rx_esc;
            r_tx_ch_valid <= n_tx_ch_valid;
            r_tx_ch       <= n_tx_ch;
            r_ls_valid    <= n_ls_valid;
            r_ls_esc      <= n_ls_esc;
            r_ls_byte     <= n_ls_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slm_queue.sv
`default_nettype none

module slm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire slm_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output slm_pkg::t_job      o_head
);

    slm_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/slm_back.sv
`default_nettype none

module slm_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_head_valid,
    input  wire slm_pkg::t_job              i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_dest,
    output logic [slm_pkg::BYTE_W-1:0]      o_chan,
    output logic [slm_pkg::BYTE_W-1:0]      o_byte,
    output logic                            o_last
);

    logic                          r_valid;
    logic                          r_dest;
    logic [slm_pkg::BYTE_W-1:0]    r_chan;
    logic [slm_pkg::BYTE_W-1:0]    r_byte;
    logic                          r_last;
    logic [slm_pkg::JOB_CNT_W-1:0] r_idx;

    logic load;
    logic at_end;

    assign load   = !r_valid || i_ready;
    assign at_end = (r_idx == (i_head.count - 2'd1));
    assign o_pop  = load && i_head_valid && at_end;

    assign o_valid = r_valid;
    assign o_dest  = r_dest;
    assign o_chan  = r_chan;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_dest <= i_head.dest;
            r_chan <= i_head.chan;
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= at_end ? '0 : r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/serial_link_multiplexer.sv
// Serial link multiplexer: virtual channels over one byte link with channel-id bytes and
// escape stuffing. Input beats (tuser = opcode) are taken one per cycle while the
// two-entry job queue between the classifier and the serializer has room; a beat
// produces zero to three output beats. The output serializer emits one byte per cycle
// while i_m_axis_tready is high, so an item's bytes (at most 3) leave in order; the job
// queue and output register keep taking input during an output stall until it fills.
// Configuration writes take effect at once and are meant for an idle block.
`default_nettype none

module serial_link_multiplexer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [slm_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [slm_pkg::BYTE_W-1:0]       i_cfg_wdata,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [15:0]                      i_s_axis_tdata,  // channel_id, data_byte
    input  wire logic                             i_s_axis_tuser,  // opcode
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [15:0]                           o_m_axis_tdata,  // target_channel, out_byte
    output logic                                  o_m_axis_tuser,  // destination
    output logic                                  o_m_axis_tlast
);

    slm_pkg::t_cfg r_cfg;
    slm_pkg::t_job front_job;
    slm_pkg::t_job q_head;
    logic          front_push;
    logic          q_full;
    logic          q_head_valid;
    logic          back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.service_id_first <= slm_pkg::RST_SERVICE_ID_FIRST;
            r_cfg.channel_count    <= slm_pkg::RST_CHANNEL_COUNT;
            r_cfg.escape_char      <= slm_pkg::RST_ESCAPE_CHAR;
            r_cfg.force_char       <= slm_pkg::RST_FORCE_CHAR;
            r_cfg.escape_xor       <= slm_pkg::RST_ESCAPE_XOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                slm_pkg::CFG_SERVICE_ID_FIRST: r_cfg.service_id_first <= i_cfg_wdata;
                slm_pkg::CFG_CHANNEL_COUNT:
                    r_cfg.channel_count <= i_cfg_wdata[slm_pkg::COUNT_W-1:0];
                slm_pkg::CFG_ESCAPE_CHAR:      r_cfg.escape_char <= i_cfg_wdata;
                slm_pkg::CFG_FORCE_CHAR:       r_cfg.force_char  <= i_cfg_wdata;
                slm_pkg::CFG_ESCAPE_XOR:       r_cfg.escape_xor  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    slm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_opcode     (i_s_axis_tuser),
        .i_channel_id (i_s_axis_tdata[7:0]),
        .i_data_byte  (i_s_axis_tdata[15:8]),
        .i_q_full     (q_full),
        .o_push       (front_push),
        .o_job        (front_job)
    );

    slm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .i_job        (front_job),
        .o_full       (q_full),
        .i_pop        (back_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    slm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (back_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_dest       (o_m_axis_tuser),
        .o_chan       (o_m_axis_tdata[7:0]),
        .o_byte       (o_m_axis_tdata[15:8]),
        .o_last       (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // a job that carries no bytes must never enter the queue
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> (front_job.count != '0))
        else $error("empty job pushed");

    // the serializer only retires a job that is really there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> q_head_valid)
        else $error("pop from empty job queue");

    // link-side results never carry a channel
    a_link_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == slm_pkg::DEST_LINK))
            |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("link byte with nonzero channel");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
